[rtl/vmap_pkg.sv]
// Package for the video memory access port: port codes, store codes,
// payload structs and default sizes. No dependencies.
package vmap_pkg;

	// default pointer width, store depth follows as 2**ADDR_BITS
	localparam int ADDR_BITS_DEF = 13;
	localparam int DATA_BITS     = 8;
	localparam int NUM_STORES    = 4;
	localparam int STORE_SEL_BITS = 2;

	// access kind
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// port numbers
	localparam logic [3:0] PORT_SCROLL_X  = 4'h0;
	localparam logic [3:0] PORT_SCROLL_Y  = 4'h1;
	localparam logic [3:0] PORT_SCROLL_H  = 4'h2;
	localparam logic [3:0] PORT_PTR_LO    = 4'h3;
	localparam logic [3:0] PORT_PTR_HI    = 4'h4;
	localparam logic [3:0] PORT_STORE_BASE = 4'h8;
	localparam logic [3:0] PORT_INCR_BASE  = 4'hc;

	// store select, low two bits of a store port
	localparam logic [STORE_SEL_BITS-1:0] STORE_NAME      = 2'd0;
	localparam logic [STORE_SEL_BITS-1:0] STORE_ATTRIBUTE = 2'd1;
	localparam logic [STORE_SEL_BITS-1:0] STORE_PATTERN   = 2'd2;
	localparam logic [STORE_SEL_BITS-1:0] STORE_PALETTE   = 2'd3;

	typedef struct packed {
		logic                 func;
		logic [3:0]           port_select;
		logic [DATA_BITS-1:0] write_value;
	} vmap_cmd_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] read_data;
		logic [DATA_BITS-1:0] scroll_x_out;
		logic [DATA_BITS-1:0] scroll_y_out;
		logic [DATA_BITS-1:0] scroll_h_out;
	} vmap_rsp_t;

endpackage

[rtl/video_memory_access_port.sv]
// Top level of the video memory access port: scroll registers, address
// pointer and four video stores. Depends on vmap_pkg and vmap_ram.
//
// Usage: the CPU side offers one bus access per transfer on the cmd channel
// (cmd_valid/cmd_ready, payload cmd). Each access yields exactly one result
// on the rsp channel (rsp_valid/rsp_ready, payload rsp): the byte read, or 0
// for writes, reads of register ports and unmapped ports, plus the three
// scroll registers as they stand after the access.
// Path: a command passes the store read stage, where the store read is
// registered at the transfer edge, and then the output register, which
// loads from that stage once it is free.
// Throughput: one access per cycle while rsp_ready stays high, set by the
// single port of each store, which takes one read or one write per cycle.
// Reset: arst_n clears the pointer, the scroll registers and all valid flags;
// store contents are undefined until written and need no clearing pass.
// Stall: while rsp_ready is low the result holds in the output register,
// one more access may sit in the store read stage, and cmd_ready then drops
// until the result is taken.
module video_memory_access_port_core
	import vmap_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  vmap_cmd_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output vmap_rsp_t rsp
);

	localparam int DEPTH = 1 << ADDR_BITS;
	localparam int HI_BITS = ADDR_BITS - 8;

	logic                 cmd_xfer;
	logic                 store_hit;
	logic                 incr_hit;
	logic [ADDR_BITS-1:0] ptr_q, ptr_d;
	logic [DATA_BITS-1:0] scroll_x_q, scroll_x_d;
	logic [DATA_BITS-1:0] scroll_y_q, scroll_y_d;
	logic [DATA_BITS-1:0] scroll_h_q, scroll_h_d;

	logic                      valid_s1;
	logic                      rd_s1;
	logic [STORE_SEL_BITS-1:0] sel_s1;
	logic                      move_s1;

	logic                 rsp_valid_q;
	vmap_rsp_t            rsp_q;
	logic [DATA_BITS-1:0] rd_byte;

	logic [NUM_STORES-1:0] ram_wr;
	logic [NUM_STORES-1:0] ram_rd;
	logic [DATA_BITS-1:0]  ram_rdata [NUM_STORES];

	// handshake and stage advance
	assign move_s1   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !valid_s1 || move_s1;
	assign cmd_xfer  = cmd_valid && cmd_ready;

	assign store_hit = cmd.port_select >= PORT_STORE_BASE;
	assign incr_hit  = cmd.port_select >= PORT_INCR_BASE;

	// register decode and pointer update
	always_comb begin
		ptr_d      = ptr_q;
		scroll_x_d = scroll_x_q;
		scroll_y_d = scroll_y_q;
		scroll_h_d = scroll_h_q;
		if (cmd_xfer) begin
			if (store_hit) begin
				if (incr_hit) begin
					ptr_d = ptr_q + ADDR_BITS'(1);
				end
			end else if (cmd.func == FUNC_WRITE) begin
				unique case (cmd.port_select)
					PORT_SCROLL_X: scroll_x_d = cmd.write_value;
					PORT_SCROLL_Y: scroll_y_d = cmd.write_value;
					PORT_SCROLL_H: scroll_h_d = cmd.write_value;
					PORT_PTR_LO:   ptr_d = {ptr_q[ADDR_BITS-1:8], cmd.write_value};
					PORT_PTR_HI:   ptr_d = {cmd.write_value[HI_BITS-1:0], ptr_q[7:0]};
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			scroll_x_q <= '0;
			scroll_y_q <= '0;
			scroll_h_q <= '0;
		end else begin
			ptr_q      <= ptr_d;
			scroll_x_q <= scroll_x_d;
			scroll_y_q <= scroll_y_d;
			scroll_h_q <= scroll_h_d;
		end
	end

	// video stores, one enabled per store access
	for (genvar i = 0; i < NUM_STORES; i++) begin : g_store
		assign ram_wr[i] = cmd_xfer && store_hit && (cmd.func == FUNC_WRITE)
			&& (cmd.port_select[STORE_SEL_BITS-1:0] == STORE_SEL_BITS'(i));
		assign ram_rd[i] = cmd_xfer && store_hit && (cmd.func == FUNC_READ)
			&& (cmd.port_select[STORE_SEL_BITS-1:0] == STORE_SEL_BITS'(i));

		vmap_ram #(
			.WIDTH(DATA_BITS),
			.DEPTH(DEPTH)
		) u_ram (
			.clk   (clk),
			.wr_en (ram_wr[i]),
			.rd_en (ram_rd[i]),
			.addr  (ptr_q),
			.wdata (cmd.write_value),
			.rdata (ram_rdata[i])
		);
	end

	// store read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			rd_s1  <= store_hit && (cmd.func == FUNC_READ);
			sel_s1 <= cmd.port_select[STORE_SEL_BITS-1:0];
		end
	end

	// read data select
	always_comb begin
		rd_byte = '0;
		if (rd_s1) begin
			case (sel_s1)
				STORE_NAME:      rd_byte = ram_rdata[0];
				STORE_ATTRIBUTE: rd_byte = ram_rdata[1];
				STORE_PATTERN:   rd_byte = ram_rdata[2];
				STORE_PALETTE:   rd_byte = ram_rdata[3];
				default:         rd_byte = '0;
			endcase
		end
	end

	// output register, scroll values are the ones left by this access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp_ready) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			rsp_q.read_data    <= rd_byte;
			rsp_q.scroll_x_out <= scroll_x_q;
			rsp_q.scroll_y_out <= scroll_y_q;
			rsp_q.scroll_h_out <= scroll_h_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// at most one store is enabled per transfer
	a_one_store: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ram_wr | ram_rd))
		else $error("more than one store enabled");

	// incrementing store ports step the pointer by one
	a_ptr_incr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_xfer && incr_hit) |=> (ptr_q == $past(ptr_q) + ADDR_BITS'(1)))
		else $error("pointer did not post-increment");

	// a result without a store read carries zero read data
	a_zero_read: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && !rd_s1) |=> (rsp.read_data == '0))
		else $error("nonzero read data for write or unmapped access");

	// the read stage is never overwritten while its item is held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !move_s1) |-> !cmd_ready)
		else $error("command accepted over a held read stage");
`endif

endmodule

[rtl/vmap_ram.sv]
// Generic single-port RAM with registered read, contents undefined until written.
// No dependencies.
module vmap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one access per cycle, read data held until the next read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end else if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[test/tb_video_memory_access_port_core.sv]
// Testbench for video_memory_access_port_core: directed and random bus accesses
// checked against an in-bench model of the scroll registers, pointer and stores.
// Depends on vmap_pkg and the rtl of the access port.
module tb_video_memory_access_port_core;
	import vmap_pkg::*;

	localparam int PTR_W = ADDR_BITS_DEF;
	localparam int DEPTH = 2 ** PTR_W;
	localparam int RANDOM_ITEMS = 1300;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	vmap_cmd_t cmd = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	vmap_rsp_t rsp;

	// model state of the port
	logic [PTR_W-1:0]     ptr_model;
	logic [DATA_BITS-1:0] scroll_x_model;
	logic [DATA_BITS-1:0] scroll_y_model;
	logic [DATA_BITS-1:0] scroll_h_model;
	logic [DATA_BITS-1:0] vram_model [NUM_STORES][DEPTH];
	bit                   vram_written [NUM_STORES][DEPTH];

	vmap_rsp_t expected_rsp_q[$];
	int        err_count = 0;
	int        cycle_count = 0;
	int        hold_cycles = 0;
	bit        tx_steady = 1'b0;
	bit        rx_steady = 1'b0;

	video_memory_access_port_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one access to the model, return the result it yields
	function automatic vmap_rsp_t predict_access(input vmap_cmd_t c);
		vmap_rsp_t r;
		logic [STORE_SEL_BITS-1:0] sel;
		r = '0;
		sel = c.port_select[STORE_SEL_BITS-1:0];
		if (c.port_select >= PORT_STORE_BASE) begin
			if (c.func == FUNC_WRITE) begin
				vram_model[sel][ptr_model] = c.write_value;
				vram_written[sel][ptr_model] = 1'b1;
			end else begin
				r.read_data = vram_model[sel][ptr_model];
			end
			if (c.port_select >= PORT_INCR_BASE)
				ptr_model = ptr_model + 1'b1;
		end else if (c.func == FUNC_WRITE) begin
			case (c.port_select)
				PORT_SCROLL_X: scroll_x_model = c.write_value;
				PORT_SCROLL_Y: scroll_y_model = c.write_value;
				PORT_SCROLL_H: scroll_h_model = c.write_value;
				PORT_PTR_LO: ptr_model = PTR_W'({ptr_model[PTR_W-1:8], c.write_value});
				// bits above the pointer width fall off
				PORT_PTR_HI: ptr_model = PTR_W'({c.write_value, ptr_model[7:0]});
				default: ;
			endcase
		end
		r.scroll_x_out = scroll_x_model;
		r.scroll_y_out = scroll_y_model;
		r.scroll_h_out = scroll_h_model;
		return r;
	endfunction

	// sender idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (tx_steady || roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one access on the cmd channel; a read of a never-written entry becomes a write
	task automatic issue_access(input logic f, input logic [3:0] p, input logic [7:0] v);
		vmap_cmd_t c;
		int gap;
		c.func = f;
		c.port_select = p;
		c.write_value = v;
		if (c.func == FUNC_READ && c.port_select >= PORT_STORE_BASE &&
				!vram_written[c.port_select[STORE_SEL_BITS-1:0]][ptr_model])
			c.func = FUNC_WRITE;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		expected_rsp_q.push_back(predict_access(c));
	endtask

	// load both pointer bytes; junk goes into the bits above the pointer width
	task automatic set_pointer(input int addr, input int junk);
		logic [15:0] a;
		a = 16'(addr) | (16'(junk) << PTR_W);
		issue_access(FUNC_WRITE, PORT_PTR_LO, a[7:0]);
		issue_access(FUNC_WRITE, PORT_PTR_HI, a[15:8]);
	endtask

	// scroll registers and unmapped ports
	task automatic test_scroll_registers();
		issue_access(FUNC_WRITE, PORT_SCROLL_X, 8'hff);
		issue_access(FUNC_WRITE, PORT_SCROLL_Y, 8'h00);
		issue_access(FUNC_WRITE, PORT_SCROLL_H, 8'ha5);
		issue_access(FUNC_READ, PORT_SCROLL_X, 8'hff);
		issue_access(FUNC_READ, 4'h7, 8'h00);
		issue_access(FUNC_WRITE, 4'h5, 8'hff);
		issue_access(FUNC_WRITE, 4'h7, 8'h5a);
	endtask

	// pointer byte loads, dropped high bits and wrap at the top address
	task automatic test_pointer_bytes();
		issue_access(FUNC_WRITE, PORT_PTR_LO, 8'hff);
		issue_access(FUNC_WRITE, PORT_PTR_HI, 8'hff);
		issue_access(FUNC_WRITE, PORT_INCR_BASE | {2'b00, STORE_PALETTE}, 8'h00);
		issue_access(FUNC_WRITE, PORT_INCR_BASE | {2'b00, STORE_NAME}, 8'hff);
		// low byte load keeps the high part
		issue_access(FUNC_WRITE, PORT_PTR_HI, 8'h1f);
		issue_access(FUNC_WRITE, PORT_PTR_LO, 8'hff);
		issue_access(FUNC_READ, PORT_STORE_BASE | {2'b00, STORE_PALETTE}, 8'h00);
		issue_access(FUNC_READ, PORT_INCR_BASE | {2'b00, STORE_PALETTE}, 8'h00);
		issue_access(FUNC_READ, PORT_STORE_BASE | {2'b00, STORE_NAME}, 8'h00);
	endtask

	// attribute and pattern stores, with and without post-increment
	task automatic test_store_ports();
		set_pointer(16, 0);
		issue_access(FUNC_WRITE, PORT_STORE_BASE | {2'b00, STORE_ATTRIBUTE}, 8'h3c);
		issue_access(FUNC_WRITE, PORT_STORE_BASE | {2'b00, STORE_PATTERN}, 8'hc3);
		issue_access(FUNC_WRITE, PORT_INCR_BASE | {2'b00, STORE_ATTRIBUTE}, 8'h81);
		issue_access(FUNC_WRITE, PORT_INCR_BASE | {2'b00, STORE_PATTERN}, 8'h7e);
		set_pointer(16, 0);
		issue_access(FUNC_READ, PORT_INCR_BASE | {2'b00, STORE_ATTRIBUTE}, 8'h00);
		issue_access(FUNC_READ, PORT_STORE_BASE | {2'b00, STORE_PATTERN}, 8'h00);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_hold_off();
		tx_steady = 1'b1;
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (24)
			issue_access(1'($urandom), 4'($urandom), 8'($urandom));
		tx_steady = 1'b0;
	endtask

	// write bursts read back through random store ports, mixed with noise
	task automatic test_random_traffic();
		int sent;
		int base;
		int len;
		int roll;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			tx_steady = ($urandom_range(0, 9) == 0);
			rx_steady = ($urandom_range(0, 9) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				roll = $urandom_range(0, 9);
				if (roll < 7)
					base = $urandom_range(0, 63);
				else if (roll < 9)
					base = $urandom_range(DEPTH - 32, DEPTH - 1);
				else
					base = $urandom_range(0, DEPTH - 1);
				len = $urandom_range(1, 16);
				set_pointer(base, $urandom);
				repeat (len)
					issue_access(FUNC_WRITE, PORT_STORE_BASE + 4'($urandom_range(0, 7)),
						8'($urandom));
				set_pointer(base, $urandom);
				repeat (len)
					issue_access(FUNC_READ, PORT_STORE_BASE + 4'($urandom_range(0, 7)),
						8'($urandom));
				sent += 2 * len + 4;
			end else begin
				len = $urandom_range(1, 8);
				repeat (len)
					issue_access(1'($urandom), 4'($urandom), 8'($urandom));
				sent += len;
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// result side ready: random runs, steady stretches, requested hold-off
	initial begin
		int run_left;
		run_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				hold_cycles--;
				run_left = 0;
			end else if (rx_steady) begin
				rsp_ready <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) < 70);
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
					$urandom_range(0, 3);
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			err_count++;
		end
	endfunction

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		vmap_rsp_t exp_r;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				$error("result transfer with no access pending: %0h", rsp);
				err_count++;
			end else begin
				exp_r = expected_rsp_q.pop_front();
				check_field("read_data", exp_r.read_data, rsp.read_data);
				check_field("scroll_x_out", exp_r.scroll_x_out, rsp.scroll_x_out);
				check_field("scroll_y_out", exp_r.scroll_y_out, rsp.scroll_y_out);
				check_field("scroll_h_out", exp_r.scroll_h_out, rsp.scroll_h_out);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[video_memory_access_port_core] ERROR");
			$finish;
		end
	end

	// test sequence
	initial begin
		ptr_model = '0;
		scroll_x_model = '0;
		scroll_y_model = '0;
		scroll_h_model = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_scroll_registers();
		test_pointer_bytes();
		test_store_ports();
		test_hold_off();
		test_random_traffic();
		@(negedge clk);
		cmd_valid <= 1'b0;
		wait (expected_rsp_q.size() == 0);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("[video_memory_access_port_core] OK");
		else
			$display("[video_memory_access_port_core] ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/vmap_pkg.sv
rtl/vmap_ram.sv
rtl/video_memory_access_port.sv
test/tb_video_memory_access_port_core.sv
